// File: hdl/hufdec_pkg.sv
package hufdec_pkg;

  // Field widths fixed by the stream format
  localparam int IDX_W         = 9;
  localparam int SYM_W         = 8;
  localparam int BITS_PER_BYTE = 8;
  localparam int VB_W          = 4;

  // Input function codes
  localparam logic FUNC_NODE_WRITE = 1'b0;
  localparam logic FUNC_DECODE     = 1'b1;

  // One node table entry: leaf flag, symbol, left child, right child
  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_child;
  } node_t;

  // Classified command handed from the front end to the tree walker
  typedef struct packed {
    logic                     is_decode;
    logic [IDX_W-1:0]         node_index;
    node_t                    node;
    logic [BITS_PER_BYTE-1:0] data_byte;
    logic [VB_W-1:0]          bit_count;
    logic                     stream_end;
  } cmd_t;

endpackage

// File: hdl/hufdec_front.sv
module hufdec_front #(
  parameter int NODE_COUNT = 512
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_func,
  input  logic [hufdec_pkg::IDX_W-1:0]           in_node_index,
  input  logic                                   in_node_is_leaf,
  input  logic [hufdec_pkg::SYM_W-1:0]           in_node_symbol,
  input  logic [hufdec_pkg::IDX_W-1:0]           in_left_child,
  input  logic [hufdec_pkg::IDX_W-1:0]           in_right_child,
  input  logic [hufdec_pkg::BITS_PER_BYTE-1:0]   in_data_byte,
  input  logic [hufdec_pkg::VB_W-1:0]            in_valid_bits,
  input  logic                                   in_stream_end,
  output logic                                   cmd_valid,
  input  logic                                   cmd_ready,
  output hufdec_pkg::cmd_t                       cmd
);
  import hufdec_pkg::*;

  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = QP_W + 1;

  localparam logic [IDX_W:0]  NODE_LIMIT = (IDX_W+1)'(NODE_COUNT);
  localparam logic [VB_W-1:0] VB_MAX     = VB_W'(BITS_PER_BYTE);
  localparam logic [QC_W-1:0] QC_FULL    = QC_W'(QUEUE_DEPTH);

  cmd_t            cls;
  logic            keep;
  logic            push;
  logic            pop;
  cmd_t            queue_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r;
  logic [QP_W-1:0] wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r;
  logic [QP_W-1:0] rd_ptr_nxt;
  logic [QC_W-1:0] count_r;
  logic [QC_W-1:0] count_nxt;

  // Classify the incoming transaction and clamp the bit count
  always_comb begin
    cls.is_decode        = (in_func == FUNC_DECODE);
    cls.node_index       = in_node_index;
    cls.node.leaf        = in_node_is_leaf;
    cls.node.symbol      = in_node_symbol;
    cls.node.left_child  = in_left_child;
    cls.node.right_child = in_right_child;
    cls.data_byte        = in_data_byte;
    cls.bit_count        = (in_valid_bits > VB_MAX) ? VB_MAX : in_valid_bits;
    cls.stream_end       = in_stream_end;
  end

  // Drop writes beyond the table and bytes that can have no effect
  always_comb begin
    if (cls.is_decode) begin
      keep = (in_valid_bits != '0) || in_stream_end;
    end else begin
      keep = ({1'b0, in_node_index} < NODE_LIMIT);
    end
  end

  assign in_ready  = (count_r != QC_FULL);
  assign cmd_valid = (count_r != '0);
  assign cmd       = queue_r[rd_ptr_r];
  assign push      = in_valid && in_ready && keep;
  assign pop       = cmd_valid && cmd_ready;

  // Advance queue pointers
  always_comb begin
    wr_ptr_nxt = push ? QP_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QP_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = QC_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = QC_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: hdl/hufdec_back.sv
module hufdec_back #(
  parameter int NODE_COUNT = 512
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [hufdec_pkg::IDX_W-1:0] cfg_root_index,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  hufdec_pkg::cmd_t             cmd,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hufdec_pkg::SYM_W-1:0] out_symbol,
  output logic                         out_truncated,
  output logic                         out_last_of_item
);
  import hufdec_pkg::*;

  localparam int             ADDR_W     = $clog2(NODE_COUNT);
  localparam logic [IDX_W:0] NODE_LIMIT = (IDX_W+1)'(NODE_COUNT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_WALK,
    S_FLUSH
  } state_t;

  state_t                   state_r,      state_nxt;
  logic [IDX_W-1:0]         root_r,       root_nxt;
  logic [IDX_W-1:0]         walk_pos_r,   walk_pos_nxt;
  logic                     mid_r,        mid_nxt;
  logic                     root_ok_r,    root_ok_nxt;
  node_t                    root_node_r,  root_node_nxt;
  node_t                    cur_node_r,   cur_node_nxt;
  logic                     use_rd_r,     use_rd_nxt;
  logic [BITS_PER_BYTE-1:0] byte_r,       byte_nxt;
  logic [VB_W-1:0]          vb_r,         vb_nxt;
  logic                     end_r,        end_nxt;
  logic [VB_W-1:0]          bit_cnt_r,    bit_cnt_nxt;
  logic                     pend_v_r,     pend_v_nxt;
  logic [SYM_W-1:0]         pend_sym_r,   pend_sym_nxt;
  logic                     pend_trunc_r, pend_trunc_nxt;
  logic                     out_v_r,      out_v_nxt;
  logic [SYM_W-1:0]         out_sym_r,    out_sym_nxt;
  logic                     out_trunc_r,  out_trunc_nxt;
  logic                     out_last_r,   out_last_nxt;

  node_t                    node_mem [NODE_COUNT];
  node_t                    rd_data_r;
  logic                     rd_oob_r;
  logic                     rd_re;
  logic [IDX_W-1:0]         rd_idx;
  logic                     rd_in_range;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     mem_we;

  node_t                    rd_node;
  node_t                    cur_c;
  logic                     slot_ok;
  logic                     hit;
  logic                     bits_left;
  logic                     trunc_now;
  logic                     produce;
  logic                     stall;
  logic [IDX_W-1:0]         next_idx;
  logic [SYM_W-1:0]         new_sym;

  // Entries beyond the table read as an all-zero node
  assign rd_node     = rd_oob_r ? node_t'('0) : rd_data_r;
  assign rd_in_range = ({1'b0, rd_idx} < NODE_LIMIT);
  assign rd_addr     = rd_in_range ? rd_idx[ADDR_W-1:0] : '0;

  // Tree step: test the node just reached, then pick the child for the next bit
  assign slot_ok   = !out_v_r || out_ready;
  assign hit       = use_rd_r && rd_node.leaf;
  assign cur_c     = hit ? root_node_r : (use_rd_r ? rd_node : cur_node_r);
  assign bits_left = (bit_cnt_r != vb_r);
  assign trunc_now = !bits_left && !hit && end_r && mid_r;
  assign produce   = (state_r == S_WALK) && (hit || trunc_now);
  assign stall     = produce && pend_v_r && !slot_ok;
  assign next_idx  = byte_r[BITS_PER_BYTE-1] ? cur_c.right_child : cur_c.left_child;
  assign new_sym   = hit ? rd_node.symbol : '0;

  always_comb begin
    state_nxt      = state_r;
    root_nxt       = root_r;
    walk_pos_nxt   = walk_pos_r;
    mid_nxt        = mid_r;
    root_ok_nxt    = root_ok_r;
    root_node_nxt  = root_node_r;
    cur_node_nxt   = cur_node_r;
    use_rd_nxt     = use_rd_r;
    byte_nxt       = byte_r;
    vb_nxt         = vb_r;
    end_nxt        = end_r;
    bit_cnt_nxt    = bit_cnt_r;
    pend_v_nxt     = pend_v_r;
    pend_sym_nxt   = pend_sym_r;
    pend_trunc_nxt = pend_trunc_r;
    out_v_nxt      = out_v_r;
    out_sym_nxt    = out_sym_r;
    out_trunc_nxt  = out_trunc_r;
    out_last_nxt   = out_last_r;
    rd_re          = 1'b0;
    rd_idx         = walk_pos_r;
    mem_we         = 1'b0;
    cmd_ready      = 1'b0;

    // Drop the output transaction once taken
    if (out_ready) begin
      out_v_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd.is_decode) begin
            byte_nxt    = cmd.data_byte;
            vb_nxt      = cmd.bit_count;
            end_nxt     = cmd.stream_end;
            bit_cnt_nxt = '0;
            rd_re       = 1'b1;
            rd_idx      = walk_pos_r;
            state_nxt   = S_LOAD;
          end else begin
            mem_we = 1'b1;
            if (cmd.node_index == root_r) begin
              root_node_nxt = cmd.node;
              root_ok_nxt   = 1'b1;
            end
          end
        end
      end

      S_LOAD: begin
        // Current node arrives; at a code boundary it is the root
        cur_node_nxt = rd_node;
        use_rd_nxt   = 1'b0;
        if (!mid_r) begin
          root_node_nxt = rd_node;
          root_ok_nxt   = 1'b1;
        end
        state_nxt = S_WALK;
      end

      S_WALK: begin
        if (!stall) begin
          // Release the held result and keep the new one
          if (produce) begin
            if (pend_v_r) begin
              out_v_nxt     = 1'b1;
              out_sym_nxt   = pend_sym_r;
              out_trunc_nxt = pend_trunc_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt     = 1'b1;
            pend_sym_nxt   = new_sym;
            pend_trunc_nxt = !hit;
          end
          if (hit && !root_ok_r) begin
            walk_pos_nxt = root_r;
            mid_nxt      = 1'b0;
            rd_re        = 1'b1;
            rd_idx       = root_r;
            state_nxt    = S_LOAD;
          end else if (bits_left) begin
            rd_re        = 1'b1;
            rd_idx       = next_idx;
            walk_pos_nxt = next_idx;
            mid_nxt      = 1'b1;
            bit_cnt_nxt  = VB_W'(bit_cnt_r + 1'b1);
            byte_nxt     = {byte_r[BITS_PER_BYTE-2:0], 1'b0};
            use_rd_nxt   = 1'b1;
          end else begin
            if (hit || trunc_now) begin
              walk_pos_nxt = root_r;
              mid_nxt      = 1'b0;
            end
            use_rd_nxt = 1'b0;
            state_nxt  = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        // Mark the held result as the last one of this byte
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (slot_ok) begin
          out_v_nxt     = 1'b1;
          out_sym_nxt   = pend_sym_r;
          out_trunc_nxt = pend_trunc_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Root write restarts the walk and invalidates the cached root node
    if (cfg_valid) begin
      root_nxt     = cfg_root_index;
      walk_pos_nxt = cfg_root_index;
      mid_nxt      = 1'b0;
      root_ok_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      root_r     <= '0;
      walk_pos_r <= '0;
      mid_r      <= 1'b0;
      root_ok_r  <= 1'b0;
      use_rd_r   <= 1'b0;
      bit_cnt_r  <= '0;
      vb_r       <= '0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      root_r     <= root_nxt;
      walk_pos_r <= walk_pos_nxt;
      mid_r      <= mid_nxt;
      root_ok_r  <= root_ok_nxt;
      use_rd_r   <= use_rd_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      vb_r       <= vb_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
    end
    root_node_r  <= root_node_nxt;
    cur_node_r   <= cur_node_nxt;
    byte_r       <= byte_nxt;
    end_r        <= end_nxt;
    pend_sym_r   <= pend_sym_nxt;
    pend_trunc_r <= pend_trunc_nxt;
    out_sym_r    <= out_sym_nxt;
    out_trunc_r  <= out_trunc_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Node table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[cmd.node_index[ADDR_W-1:0]] <= cmd.node;
    end
    if (rd_re) begin
      rd_data_r <= node_mem[rd_addr];
      rd_oob_r  <= !rd_in_range;
    end
  end

  assign out_valid        = out_v_r;
  assign out_symbol       = out_sym_r;
  assign out_truncated    = out_trunc_r;
  assign out_last_of_item = out_last_r;

endmodule

// File: hdl/huffman_tree_walk_decoder_core.sv
// Decode byte: the walker runs dequeue, node fetch, one step per bit, end check and flush,
// stalling while out_ready holds a result; the root node is cached on the first byte after
// reset or a root_index write. Node writes are taken while idle. Throughput is one tree
// step a cycle, set by the node table read port, while no result is held up. A result
// waits as pending until the next result or the flush state moves it to the output register.
// Reset (rst_n low, synchronous) empties the queue and output; node table is not cleared.
module huffman_tree_walk_decoder_core #(
  parameter int NODE_COUNT = 512
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hufdec_pkg::IDX_W-1:0]         cfg_root_index,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_func,
  input  logic [hufdec_pkg::IDX_W-1:0]         in_node_index,
  input  logic                                 in_node_is_leaf,
  input  logic [hufdec_pkg::SYM_W-1:0]         in_node_symbol,
  input  logic [hufdec_pkg::IDX_W-1:0]         in_left_child,
  input  logic [hufdec_pkg::IDX_W-1:0]         in_right_child,
  input  logic [hufdec_pkg::BITS_PER_BYTE-1:0] in_data_byte,
  input  logic [hufdec_pkg::VB_W-1:0]          in_valid_bits,
  input  logic                                 in_stream_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [hufdec_pkg::SYM_W-1:0]         out_symbol,
  output logic                                 out_truncated,
  output logic                                 out_last_of_item
);
  import hufdec_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Root register is always writable
  assign cfg_ready = 1'b1;

  hufdec_front #(
    .NODE_COUNT (NODE_COUNT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_node_index   (in_node_index),
    .in_node_is_leaf (in_node_is_leaf),
    .in_node_symbol  (in_node_symbol),
    .in_left_child   (in_left_child),
    .in_right_child  (in_right_child),
    .in_data_byte    (in_data_byte),
    .in_valid_bits   (in_valid_bits),
    .in_stream_end   (in_stream_end),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .cmd             (cmd)
  );

  hufdec_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_root_index   (cfg_root_index),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .cmd              (cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_symbol       (out_symbol),
    .out_truncated    (out_truncated),
    .out_last_of_item (out_last_of_item)
  );

endmodule
